// ===== rtl/bmms_pkg.sv =====
// ----------------------------------------------------------------------------
// Block matching motion search package
// Shared types and constants for the motion search controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bmms_pkg;

    localparam int BLOCK_SIZE  = 8;
    localparam int MAX_OFFSETS = 64;

    localparam logic [1:0] OP_LOAD_SRC = 2'd0;
    localparam logic [1:0] OP_LOAD_REF = 2'd1;
    localparam logic [1:0] OP_SEARCH   = 2'd2;

    localparam logic [1:0] CFG_X_RANGE = 2'd0;
    localparam logic [1:0] CFG_Y_RANGE = 2'd1;
    localparam logic [1:0] CFG_V_STEP  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [7:0]  pixel;
        logic [13:0] init_sad;
        logic [5:0]  init_x;
        logic [5:0]  init_y;
    } t_in_item;

    typedef struct packed {
        logic [13:0] best_sad;
        logic [5:0]  best_x;
        logic [5:0]  best_y;
        logic        improved;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       start;      // load initial best values
        logic       rd_en;      // issue a pixel read at (cy, cx, pr, pc)
        logic [5:0] cy;
        logic [5:0] cx;
        logic [2:0] pr;
        logic [2:0] pc;
        logic       first;      // first pixel of a candidate
        logic       last;       // last pixel of a candidate
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== rtl/block_matching_motion_search.sv =====
// ----------------------------------------------------------------------------
// Block matching motion search
// 8x8 SAD motion search over a loaded window, stepping rows by one or two.
// ----------------------------------------------------------------------------
// Load items are written straight into the pixel memories. For each candidate, a
// search item reads one source/window pixel pair per cycle from single-read-port
// memories, then waits for the pipeline to drain; its result then waits for the
// taker.
`default_nettype none

module block_matching_motion_search
    import bmms_pkg::*;
#(
    parameter int WINDOW_W = 72,
    parameter int WINDOW_H = 72
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [6:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output      logic       o_in_ready,
    input  wire t_in_item   i_in_item,
    output      logic       o_out_valid,
    input  wire logic       i_out_ready,
    output      t_out_item  o_out_item
);

    logic    src_we, ref_we, dp_idle;
    t_dp_cmd cmd;

    bmms_ctrl #(.WINDOW_W(WINDOW_W), .WINDOW_H(WINDOW_H)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_src_we    (src_we),
        .o_ref_we    (ref_we),
        .o_cmd       (cmd),
        .i_dp_idle   (dp_idle)
    );

    bmms_datapath #(.WINDOW_W(WINDOW_W), .WINDOW_H(WINDOW_H)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src_we (src_we),
        .i_ref_we (ref_we),
        .i_item   (i_in_item),
        .i_cmd    (cmd),
        .o_result (o_out_item),
        .o_idle   (dp_idle)
    );

endmodule

`default_nettype wire

// ===== rtl/bmms_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bmms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bmms_datapath.sv =====
// ----------------------------------------------------------------------------
// Motion search datapath
// Pixel stores, absolute difference accumulation and best candidate tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module bmms_datapath
    import bmms_pkg::*;
#(
    parameter int WINDOW_W = 72,
    parameter int WINDOW_H = 72
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_src_we,
    input  wire logic      i_ref_we,
    input  wire t_in_item  i_item,
    input  wire t_dp_cmd   i_cmd,
    output      t_out_item o_result,
    output      logic      o_idle
);

    localparam int REF_DEPTH = WINDOW_W * WINDOW_H;
    localparam int RA_W      = $clog2(REF_DEPTH);
    localparam int ROW_W     = $clog2(WINDOW_H);
    localparam int COL_W     = $clog2(WINDOW_W);

    logic [5:0]    src_waddr;
    logic [5:0]    src_raddr;
    logic [RA_W-1:0] ref_waddr;
    logic [RA_W-1:0] ref_raddr;
    logic [7:0]    src_pix;
    logic [7:0]    ref_pix;
    logic [ROW_W:0] rd_row;
    logic [COL_W:0] rd_col;
    logic [ROW_W:0] wr_row;
    logic [COL_W:0] wr_col;

    assign src_waddr = {i_item.row[2:0], i_item.col[2:0]};
    assign src_raddr = {i_cmd.pr, i_cmd.pc};
    assign wr_row    = (ROW_W + 1)'(i_item.row);
    assign wr_col    = (COL_W + 1)'(i_item.col);
    assign rd_row    = (ROW_W + 1)'(i_cmd.cy) + (ROW_W + 1)'(i_cmd.pr);
    assign rd_col    = (COL_W + 1)'(i_cmd.cx) + (COL_W + 1)'(i_cmd.pc);
    assign ref_waddr = RA_W'(wr_row) * RA_W'(WINDOW_W) + RA_W'(wr_col);
    assign ref_raddr = RA_W'(rd_row) * RA_W'(WINDOW_W) + RA_W'(rd_col);

    bmms_ram #(.WIDTH(8), .DEPTH(BLOCK_SIZE * BLOCK_SIZE)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (i_src_we),
        .i_waddr (src_waddr),
        .i_wdata (i_item.pixel),
        .i_raddr (src_raddr),
        .o_rdata (src_pix)
    );

    bmms_ram #(.WIDTH(8), .DEPTH(REF_DEPTH)) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (i_ref_we),
        .i_waddr (ref_waddr),
        .i_wdata (i_item.pixel),
        .i_raddr (ref_raddr),
        .o_rdata (ref_pix)
    );

    // Stage 1: read issued. Stage 2: absolute difference registered.
    // Stage 3: accumulate. Stage 4: compare against best.
    logic        r_v1, r_v2, r_v3;
    logic        r_f1, r_f2;
    logic        r_l1, r_l2, r_l3;
    logic [5:0]  r_x1, r_x2, r_x3, r_y1, r_y2, r_y3;
    logic [7:0]  r_ad;
    logic [13:0] r_acc;
    logic [13:0] n_acc;
    logic [13:0] r_best;
    logic [5:0]  r_bx, r_by;
    logic        r_imp;
    logic [7:0]  ad;

    assign ad    = (ref_pix > src_pix) ? ref_pix - src_pix : src_pix - ref_pix;
    assign n_acc = (r_f2 ? 14'd0 : r_acc) + 14'(r_ad);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_l2;
        end
        r_f1 <= i_cmd.first;
        r_l1 <= i_cmd.last;
        r_x1 <= i_cmd.cx;
        r_y1 <= i_cmd.cy;
        r_f2 <= r_f1;
        r_l2 <= r_l1;
        r_x2 <= r_x1;
        r_y2 <= r_y1;
        r_ad <= ad;
        r_l3 <= r_l2;
        r_x3 <= r_x2;
        r_y3 <= r_y2;
        if (r_v2) begin
            r_acc <= n_acc;
        end
        if (i_cmd.start) begin
            r_best <= i_item.init_sad;
            r_bx   <= i_item.init_x;
            r_by   <= i_item.init_y;
            r_imp  <= 1'b0;
        end else if (r_v3 && r_l3 && (r_acc < r_best)) begin
            r_best <= r_acc;
            r_bx   <= r_x3;
            r_by   <= r_y3;
            r_imp  <= 1'b1;
        end
    end

    assign o_idle            = !r_v1 && !r_v2 && !r_v3;
    assign o_result.best_sad = r_best;
    assign o_result.best_x   = r_bx;
    assign o_result.best_y   = r_by;
    assign o_result.improved = r_imp;

endmodule

`default_nettype wire

// ===== rtl/bmms_ctrl.sv =====
// ----------------------------------------------------------------------------
// Motion search controller
// Walks candidates and pixels, and runs the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bmms_ctrl
    import bmms_pkg::*;
#(
    parameter int WINDOW_W = 72,
    parameter int WINDOW_H = 72
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic [6:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic     i_in_valid,
    output      logic     o_in_ready,
    input  wire t_in_item i_item,
    output      logic     o_out_valid,
    input  wire logic     i_out_ready,
    output      logic     o_src_we,
    output      logic     o_ref_we,
    output      t_dp_cmd  o_cmd,
    input  wire logic     i_dp_idle
);

    localparam int XLIM = (WINDOW_W - 7 < MAX_OFFSETS) ? WINDOW_W - 7 : MAX_OFFSETS;
    localparam int YLIM = (WINDOW_H - 7 < MAX_OFFSETS) ? WINDOW_H - 7 : MAX_OFFSETS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state     r_state;
    logic [6:0] r_x_range, r_y_range;
    logic [1:0] r_v_step;
    logic [6:0] r_xb, r_yb;
    logic       r_step2;
    logic [5:0] r_cy, r_cx;
    logic [2:0] r_pr, r_pc;
    logic       r_out_valid;
    logic       accept;
    logic       last_pix;
    logic [6:0] nx, ny;

    assign accept   = i_in_valid && o_in_ready;
    assign last_pix = (r_pr == 3'd7) && (r_pc == 3'd7);
    assign nx       = 7'(r_cx) + 7'd1;
    assign ny       = 7'(r_cy) + (r_step2 ? 7'd2 : 7'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_x_range   <= 7'd64;
            r_y_range   <= 7'd64;
            r_v_step    <= 2'd2;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index[1:0])
                    CFG_X_RANGE: if (i_cfg_index[6:2] == 5'd0) r_x_range <= i_cfg_data;
                    CFG_Y_RANGE: if (i_cfg_index[6:2] == 5'd0) r_y_range <= i_cfg_data;
                    CFG_V_STEP:  if (i_cfg_index[6:2] == 5'd0) r_v_step <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_item.opcode == OP_SEARCH) begin
                        r_xb    <= (r_x_range < 7'(XLIM)) ? r_x_range : 7'(XLIM);
                        r_yb    <= (r_y_range < 7'(YLIM)) ? r_y_range : 7'(YLIM);
                        r_step2 <= r_v_step[1];
                        r_cx    <= 6'd0;
                        r_cy    <= 6'd0;
                        r_pr    <= 3'd0;
                        r_pc    <= 3'd0;
                        if ((r_x_range == 7'd0) || (r_y_range == 7'd0)) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    {r_pr, r_pc} <= {r_pr, r_pc} + 6'd1;
                    if (last_pix) begin
                        if (nx < r_xb) begin
                            r_cx <= nx[5:0];
                        end else begin
                            r_cx <= 6'd0;
                            if (ny < r_yb) begin
                                r_cy <= ny[5:0];
                            end else begin
                                r_state <= S_DRAIN;
                            end
                        end
                    end
                end
                S_DRAIN: begin
                    if (i_dp_idle) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_src_we    = accept && (i_item.opcode == OP_LOAD_SRC)
                         && (i_item.row < 7'd8) && (i_item.col < 7'd8);
    assign o_ref_we    = accept && (i_item.opcode == OP_LOAD_REF)
                         && (32'(i_item.row) < WINDOW_H) && (32'(i_item.col) < WINDOW_W);

    always_comb begin
        o_cmd.start = accept && (i_item.opcode == OP_SEARCH);
        o_cmd.rd_en = (r_state == S_SCAN);
        o_cmd.cy    = r_cy;
        o_cmd.cx    = r_cx;
        o_cmd.pr    = r_pr;
        o_cmd.pc    = r_pc;
        o_cmd.first = (r_pr == 3'd0) && (r_pc == 3'd0);
        o_cmd.last  = last_pix;
    end

endmodule

`default_nettype wire

// ===== rtl/bmms_checker.sv =====
// ----------------------------------------------------------------------------
// Motion search port checker
// Checks handshake and result behavior seen at the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bmms_checker
    import bmms_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire t_in_item  i_in_item,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    // A result pending means no new item is taken.
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken while result pending");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Once a search item is taken, the input is no longer ready.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.opcode == OP_SEARCH |=> !o_in_ready)
        else $error("search did not hold the input");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.opcode != OP_SEARCH |=> !o_out_valid)
        else $error("load produced a result");

endmodule

bind block_matching_motion_search bmms_checker u_bmms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ===== sim/tb_block_matching_motion_search.sv =====
// ----------------------------------------------------------------------------
// Block matching motion search testbench
// Loads source and window pixels, runs searches under several range and step
// settings, and checks every search result against a built-in SAD predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_block_matching_motion_search;
    import bmms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WIN_W     = 72;
    localparam int          WIN_H     = 72;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [13:0] SAD_MAX   = 14'd16383;

    class motion_search_scoreboard;
        logic [7:0]  src_pix [BLOCK_SIZE*BLOCK_SIZE];
        logic [7:0]  win_pix [WIN_W*WIN_H];
        bit          src_set [BLOCK_SIZE*BLOCK_SIZE];
        bit          win_set [WIN_W*WIN_H];
        int unsigned x_range = 64;
        int unsigned y_range = 64;
        int unsigned v_step  = 2;
        t_out_item   best_q[$];
        int          errors  = 0;

        function int unsigned x_bound();
            return (x_range < MAX_OFFSETS) ? x_range : MAX_OFFSETS;
        endfunction

        function int unsigned y_bound();
            return (y_range < MAX_OFFSETS) ? y_range : MAX_OFFSETS;
        endfunction

        function int unsigned y_stride();
            return v_step[1] ? 2 : 1;
        endfunction

        function int unsigned block_sad(int unsigned y, int unsigned x);
            int unsigned sum;
            int          r;
            int          s;
            sum = 0;
            for (int i = 0; i < BLOCK_SIZE; i++) begin
                for (int j = 0; j < BLOCK_SIZE; j++) begin
                    r = win_pix[(y + i) * WIN_W + x + j];
                    s = src_pix[i * BLOCK_SIZE + j];
                    sum += (r > s) ? r - s : s - r;
                end
            end
            return sum;
        endfunction

        function t_out_item best_match(t_in_item it);
            t_out_item   res;
            int unsigned best;
            int unsigned sad;
            res.best_sad = it.init_sad;
            res.best_x   = it.init_x;
            res.best_y   = it.init_y;
            res.improved = 1'b0;
            best = it.init_sad;
            for (int unsigned y = 0; y < y_bound(); y += y_stride()) begin
                for (int unsigned x = 0; x < x_bound(); x++) begin
                    sad = block_sad(y, x);
                    if (sad < best) begin
                        best         = sad;
                        res.best_sad = sad[13:0];
                        res.best_x   = x[5:0];
                        res.best_y   = y[5:0];
                        res.improved = 1'b1;
                    end
                end
            end
            return res;
        endfunction

        function void note_input(t_in_item it);
            case (it.opcode)
                OP_LOAD_SRC: begin
                    if (it.row < BLOCK_SIZE && it.col < BLOCK_SIZE) begin
                        src_pix[it.row * BLOCK_SIZE + it.col] = it.pixel;
                        src_set[it.row * BLOCK_SIZE + it.col] = 1'b1;
                    end
                end
                OP_LOAD_REF: begin
                    if (it.row < WIN_H && it.col < WIN_W) begin
                        win_pix[it.row * WIN_W + it.col] = it.pixel;
                        win_set[it.row * WIN_W + it.col] = 1'b1;
                    end
                end
                OP_SEARCH: best_q.push_back(best_match(it));
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (best_q.size() == 0) begin
                report($sformatf("unexpected result %p", got));
            end else begin
                want = best_q.pop_front();
                if (got.best_sad !== want.best_sad)
                    report($sformatf("best_sad %0d, expected %0d", got.best_sad, want.best_sad));
                if (got.best_x !== want.best_x)
                    report($sformatf("best_x %0d, expected %0d", got.best_x, want.best_x));
                if (got.best_y !== want.best_y)
                    report($sformatf("best_y %0d, expected %0d", got.best_y, want.best_y));
                if (got.improved !== want.improved)
                    report($sformatf("improved %0b, expected %0b", got.improved, want.improved));
            end
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [6:0] i_cfg_index = '0;
    logic [6:0] i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_item;

    motion_search_scoreboard sb = new();
    int  burst_left = 0;
    bit  hold_req   = 1'b0;
    int  rx_cycle   = 0;

    block_matching_motion_search #(
        .WINDOW_W (WIN_W),
        .WINDOW_H (WIN_H)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    task send_item(t_in_item it);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
        burst_left--;
    endtask

    task send_load(logic [1:0] op, int r, int c, logic [7:0] pix);
        t_in_item it;
        it        = '0;
        it.opcode = op;
        it.row    = r[6:0];
        it.col    = c[6:0];
        it.pixel  = pix;
        it.init_sad = 14'($urandom);
        it.init_x = 6'($urandom);
        it.init_y = 6'($urandom);
        send_item(it);
    endtask

    function logic [7:0] rand_pixel();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    task write_cfg(int xr, int yr, int vs);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= 7'(CFG_X_RANGE);
        i_cfg_data  <= xr[6:0];
        @(posedge i_clk);
        sb.x_range = xr;
        i_cfg_index <= 7'(CFG_Y_RANGE);
        i_cfg_data  <= yr[6:0];
        @(posedge i_clk);
        sb.y_range = yr;
        i_cfg_index <= 7'(CFG_V_STEP);
        i_cfg_data  <= vs[6:0];
        @(posedge i_clk);
        sb.v_step = vs & 3;
        i_cfg_we <= 1'b0;
    endtask

    task wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.best_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task fill_source(bit fixed, logic [7:0] v);
        for (int r = 0; r < BLOCK_SIZE; r++)
            for (int c = 0; c < BLOCK_SIZE; c++)
                send_load(OP_LOAD_SRC, r, c, fixed ? v : rand_pixel());
    endtask

    // Writes every window pixel that the current search range reads and that
    // is still unwritten, so that no search touches an undefined pixel.
    task fill_window(bit fixed, logic [7:0] v);
        int rows;
        int cols;
        rows = (sb.x_bound() == 0 || sb.y_bound() == 0) ? 0 : sb.y_bound() + BLOCK_SIZE - 1;
        cols = sb.x_bound() + BLOCK_SIZE - 1;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                if (!sb.win_set[r * WIN_W + c])
                    send_load(OP_LOAD_REF, r, c, fixed ? v : rand_pixel());
    endtask

    task send_search(logic [13:0] sad, logic [5:0] x, logic [5:0] y);
        t_in_item it;
        it          = '0;
        it.opcode   = OP_SEARCH;
        it.row      = 7'($urandom);
        it.col      = 7'($urandom);
        it.pixel    = 8'($urandom);
        it.init_sad = sad;
        it.init_x   = x;
        it.init_y   = y;
        fill_window(1'b0, 8'h00);
        send_item(it);
    endtask

    task send_noise();
        case ($urandom_range(0, 3))
            0: send_load(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127), 8'($urandom));
            1: send_load(OP_LOAD_SRC, $urandom_range(8, 127), $urandom_range(0, 127),
                         8'($urandom));
            2: send_load(OP_LOAD_SRC, $urandom_range(0, 7), $urandom_range(8, 127),
                         8'($urandom));
            default: begin
                if ($urandom_range(0, 1))
                    send_load(OP_LOAD_REF, $urandom_range(WIN_H, 127), $urandom_range(0, 127),
                              8'($urandom));
                else
                    send_load(OP_LOAD_REF, $urandom_range(0, 127), $urandom_range(WIN_W, 127),
                              8'($urandom));
            end
        endcase
    endtask

    // Copies the source block into the window at a visited offset, which
    // gives a zero SAD candidate.
    task plant_block();
        int y;
        int x;
        if (sb.x_bound() == 0 || sb.y_bound() == 0) return;
        y = $urandom_range(0, (sb.y_bound() - 1) / sb.y_stride()) * sb.y_stride();
        x = $urandom_range(0, sb.x_bound() - 1);
        for (int r = 0; r < BLOCK_SIZE; r++)
            for (int c = 0; c < BLOCK_SIZE; c++)
                send_load(OP_LOAD_REF, y + r, x + c, sb.src_pix[r * BLOCK_SIZE + c]);
    endtask

    task run_phase(int xr, int yr, int vs, int n_items, int p_search);
        int          k;
        logic [13:0] sad;
        write_cfg(xr, yr, vs);
        for (int n = 0; n < n_items; n++) begin
            k = $urandom_range(0, 99);
            if (k < p_search) begin
                case ($urandom_range(0, 3))
                    0: sad = SAD_MAX;
                    1: sad = 14'($urandom);
                    2: sad = 14'($urandom_range(0, 600));
                    default: sad = 14'($urandom_range(16321, 16383));
                endcase
                send_search(sad, 6'($urandom), 6'($urandom));
            end else if (k < p_search + 4) begin
                send_noise();
            end else if (k < p_search + 6) begin
                plant_block();
            end else if (k < p_search + 30) begin
                send_load(OP_LOAD_SRC, $urandom_range(0, 7), $urandom_range(0, 7), rand_pixel());
            end else begin
                send_load(OP_LOAD_REF, $urandom_range(0, sb.y_bound() + BLOCK_SIZE - 2),
                          $urandom_range(0, sb.x_bound() + BLOCK_SIZE - 2), rand_pixel());
            end
        end
        wait_idle();
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                case ((rx_cycle / 300) % 3)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom);
                    default: i_out_ready <= (rx_cycle % 7) < 3;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_cfg(3, 3, 1);
        fill_source(1'b1, 8'h00);
        fill_window(1'b1, 8'h00);
        send_search(SAD_MAX, 6'd5, 6'd7);
        send_search(14'd0, 6'd63, 6'd0);
        fill_source(1'b1, 8'hFF);
        send_search(SAD_MAX, 6'd1, 6'd1);
        send_search(14'd16320, 6'd0, 6'd63);
        send_search(14'd16321, 6'd42, 6'd21);
        send_load(OP_UNUSED, 127, 127, 8'hFF);
        send_load(OP_LOAD_SRC, 8, 0, 8'h00);
        send_load(OP_LOAD_SRC, 0, 127, 8'h00);
        send_load(OP_LOAD_REF, 127, 127, 8'hFF);
        send_load(OP_LOAD_REF, WIN_H, 0, 8'hFF);
        send_load(OP_LOAD_REF, 0, WIN_W, 8'hFF);
        send_search(SAD_MAX, 6'd63, 6'd63);
        wait_idle();

        run_phase(4, 4, 1, 200, 6);
        run_phase(0, 6, 1, 60, 15);
        run_phase(6, 0, 2, 60, 15);
        run_phase(127, 1, 1, 100, 3);
        run_phase(2, 127, 3, 100, 3);
        hold_req = 1'b1;
        run_phase(3, 5, 0, 200, 8);
        run_phase(7, 7, 2, 200, 5);
        run_phase(64, 1, 2, 100, 3);
        run_phase(1, 64, 1, 100, 4);
        run_phase(5, 3, 1, 200, 6);
        run_phase(2, 2, 1, 150, 10);

        if (sb.best_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.best_q.size()));
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/bmms_pkg.sv
rtl/bmms_ram.sv
rtl/bmms_datapath.sv
rtl/bmms_ctrl.sv
rtl/block_matching_motion_search.sv
rtl/bmms_checker.sv
sim/tb_block_matching_motion_search.sv
